FILE: rtl/core/integer_to_radix_ascii_core_assert.svh
// assertion macros for the integer to radix ascii core
// expects clk and arst_n in the scope where a macro is used
`ifndef INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define I2RA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2ra assertion failed");

// next-cycle implication, off during reset
`define I2RA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2ra assertion failed");

`endif

FILE: rtl/core/i2ra_pkg.sv
// shared types and constants of the integer to radix ascii core
// no dependencies
package i2ra_pkg;

	// bits of the magnitude consumed per divider cycle
	localparam int STEP_BITS = 8;

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;
	localparam logic [4:0] RADIX_TEN = 5'd10;

	localparam logic [6:0] MINUS_CHAR = 7'h2D;
	localparam logic [6:0] ERROR_CHAR = 7'h00;

	// classified transaction handed from front to back
	typedef struct packed {
		logic       err;
		logic       sign;
		logic       pow2;
		logic [2:0] shamt;
		logic [4:0] radix;
	} cls_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SIGN = 5'b00100,
		ST_READ = 5'b01000,
		ST_EMIT = 5'b10000
	} back_state_t;

	// digit value to ascii, 0-9 then uppercase A-F
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = 7'h30 + {3'b000, d};
		end else begin
			c = 7'h37 + {3'b000, d};
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/i2ra_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module i2ra_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/i2ra_fifo.sv
// short queue between the front and back parts
// no dependencies
module i2ra_fifo #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

endmodule

FILE: rtl/core/i2ra_front.sv
// front part: accepts input transactions, classifies radix and sign, takes magnitude
// depends on i2ra_pkg
module i2ra_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [4:0]                   radix,
	output logic                         push,
	input  logic                         full,
	output logic [VALUE_BITS-1:0]        mag,
	output i2ra_pkg::cls_t               cls
);

	logic [VALUE_BITS-1:0] value_u;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag_d;
	i2ra_pkg::cls_t        cls_d;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	i2ra_pkg::cls_t        cls_s1;

	assign value_u = VALUE_BITS'(unsigned'(value));
	assign neg     = value_u[VALUE_BITS-1];
	// unsigned negation, so the most negative value gives 2^(VALUE_BITS-1)
	assign mag_d   = neg ? (~value_u + 1'b1) : value_u;

	always_comb begin
		cls_d.err   = (radix < i2ra_pkg::RADIX_MIN) || (radix > i2ra_pkg::RADIX_MAX);
		cls_d.sign  = neg && (radix == i2ra_pkg::RADIX_TEN);
		cls_d.radix = radix;
		cls_d.pow2  = 1'b1;
		unique case (radix)
			5'd2:    cls_d.shamt = 3'd1;
			5'd4:    cls_d.shamt = 3'd2;
			5'd8:    cls_d.shamt = 3'd3;
			5'd16:   cls_d.shamt = 3'd4;
			default: begin
				cls_d.pow2  = 1'b0;
				cls_d.shamt = 3'd0;
			end
		endcase
	end

	assign in_stall = valid_s1 && full;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mag_s1 <= mag_d;
			cls_s1 <= cls_d;
		end
	end

	assign mag = mag_s1;
	assign cls = cls_s1;

endmodule

FILE: rtl/core/i2ra_back.sv
// back part: digit divider, digit store and character output register
// depends on i2ra_pkg and i2ra_ram
module i2ra_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [VALUE_BITS-1:0] q_mag,
	input  i2ra_pkg::cls_t        q_cls,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [6:0]            character,
	output logic                  last,
	output logic                  error
);

	localparam int SB     = i2ra_pkg::STEP_BITS;
	localparam int CHUNKS = (VALUE_BITS + SB - 1) / SB;
	localparam int WBITS  = CHUNKS * SB;
	localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int DA     = $clog2(VALUE_BITS);

	i2ra_pkg::back_state_t state_q;
	logic [WBITS-1:0] work_q;
	logic [3:0]       rem_q;
	logic [4:0]       radix_q;
	logic             pow2_q;
	logic [2:0]       shamt_q;
	logic             sign_q;
	logic [KW-1:0]    chunk_q;
	logic [DA-1:0]    cnt_q;
	logic [DA-1:0]    idx_q;

	logic             out_valid_q;
	logic [6:0]       out_char_q;
	logic             out_last_q;
	logic             out_err_q;

	logic [3:0]       step_rem;
	logic [SB-1:0]    step_bits;
	logic [WBITS-1:0] quot;
	logic             digit_done;
	logic [3:0]       digit_val;

	logic             slot_free;
	logic             out_load;
	logic [6:0]       out_char_d;
	logic             out_last_d;
	logic             out_err_d;
	logic             ram_we;
	logic             ram_re;
	logic [DA-1:0]    ram_raddr;
	logic [3:0]       ram_rdata;

	// one chunk of restoring long division, msb first
	always_comb begin : div_step
		logic [3:0] r;
		logic [4:0] t;
		r         = rem_q;
		step_bits = '0;
		for (int b = 0; b < SB; b++) begin
			t = {r, work_q[WBITS-1-b]};
			if (t >= radix_q) begin
				t = t - radix_q;
				step_bits[SB-1-b] = 1'b1;
			end
			r = t[3:0];
		end
		step_rem = r;
	end

	assign digit_done = pow2_q || (chunk_q == KW'(CHUNKS - 1));
	assign quot       = pow2_q ? (work_q >> shamt_q) : ((work_q << SB) | WBITS'(step_bits));
	assign digit_val  = pow2_q ? (work_q[3:0] & (radix_q[3:0] - 4'd1)) : step_rem;

	always_comb begin
		slot_free  = !out_valid_q || !out_stall;
		out_load   = 1'b0;
		out_char_d = i2ra_pkg::ERROR_CHAR;
		out_last_d = 1'b0;
		out_err_d  = 1'b0;
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = idx_q;
		unique case (state_q)
			i2ra_pkg::ST_IDLE: begin
				if (!q_empty && (!q_cls.err || slot_free)) begin
					q_pop = 1'b1;
					if (q_cls.err) begin
						out_load   = 1'b1;
						out_last_d = 1'b1;
						out_err_d  = 1'b1;
					end
				end
			end
			i2ra_pkg::ST_DIV: begin
				ram_we = digit_done;
			end
			i2ra_pkg::ST_SIGN: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_char_d = i2ra_pkg::MINUS_CHAR;
				end
			end
			i2ra_pkg::ST_READ: begin
				ram_re = 1'b1;
			end
			i2ra_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_char_d = i2ra_pkg::digit_char(ram_rdata);
					out_last_d = (idx_q == '0);
					// prefetch the next digit down
					if (idx_q != '0) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2ra_pkg::ST_IDLE;
			work_q      <= '0;
			rem_q       <= '0;
			radix_q     <= '0;
			pow2_q      <= 1'b0;
			shamt_q     <= '0;
			sign_q      <= 1'b0;
			chunk_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= out_load;
			end
			if (out_load) begin
				out_char_q <= out_char_d;
				out_last_q <= out_last_d;
				out_err_q  <= out_err_d;
			end
			unique case (state_q)
				i2ra_pkg::ST_IDLE: begin
					if (!q_empty && !q_cls.err) begin
						work_q  <= WBITS'(q_mag);
						rem_q   <= '0;
						radix_q <= q_cls.radix;
						pow2_q  <= q_cls.pow2;
						shamt_q <= q_cls.shamt;
						sign_q  <= q_cls.sign;
						chunk_q <= '0;
						cnt_q   <= '0;
						state_q <= i2ra_pkg::ST_DIV;
					end
				end
				i2ra_pkg::ST_DIV: begin
					work_q <= quot;
					rem_q  <= digit_done ? 4'd0 : step_rem;
					if (digit_done) begin
						chunk_q <= '0;
						cnt_q   <= cnt_q + 1'b1;
						if (quot == '0) begin
							idx_q   <= cnt_q;
							state_q <= sign_q ? i2ra_pkg::ST_SIGN : i2ra_pkg::ST_READ;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				i2ra_pkg::ST_SIGN: begin
					if (slot_free) begin
						state_q <= i2ra_pkg::ST_READ;
					end
				end
				i2ra_pkg::ST_READ: begin
					state_q <= i2ra_pkg::ST_EMIT;
				end
				i2ra_pkg::ST_EMIT: begin
					if (slot_free) begin
						if (idx_q == '0) begin
							state_q <= i2ra_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: state_q <= i2ra_pkg::ST_IDLE;
			endcase
		end
	end

	i2ra_ram #(
		.WIDTH(4),
		.DEPTH(VALUE_BITS)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q),
		.wdata(digit_val),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign character = out_char_q;
	assign last      = out_last_q;
	assign error     = out_err_q;

endmodule

FILE: rtl/core/integer_to_radix_ascii_core.sv
// top level of the integer to radix ascii converter
// depends on i2ra_pkg, i2ra_front, i2ra_fifo, i2ra_back and the assertion header
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | sink      | in_valid/in_stall  | value (signed), radix
//  out     | source    | out_valid/out_stall| character, last, error
//
// the front register takes a transaction every cycle until the queue fills
// per conversion: one pop from the queue, then one divider pass per digit, then the
// minus sign if any, one read of the top digit and one character per digit
// a divider pass is ceil(VALUE_BITS/8) steps (4 at 32 bits), 1 for radix 2, 4, 8, 16
// a bad radix gives a single error character; reset clears all control state, no clearing pass
`include "integer_to_radix_ascii_core_assert.svh"

module integer_to_radix_ascii_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [4:0]                   radix,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [6:0]                   character,
	output logic                         last,
	output logic                         error
);

	localparam int CLS_BITS = $bits(i2ra_pkg::cls_t);
	localparam int QW       = VALUE_BITS + CLS_BITS;

	// front to queue
	logic                  q_push;
	logic                  q_full;
	logic [VALUE_BITS-1:0] f_mag;
	i2ra_pkg::cls_t        f_cls;

	// queue to back
	logic                  q_pop;
	logic                  q_empty;
	logic [QW-1:0]         q_rdata;
	logic [VALUE_BITS-1:0] b_mag;
	i2ra_pkg::cls_t        b_cls;

	// accept, classify radix and sign, take the magnitude
	i2ra_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value   (value),
		.radix   (radix),
		.push    (q_push),
		.full    (q_full),
		.mag     (f_mag),
		.cls     (f_cls)
	);

	// two-entry decoupling queue of classified transactions
	i2ra_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_mag, f_cls}),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign b_mag = q_rdata[QW-1:CLS_BITS];
	assign b_cls = i2ra_pkg::cls_t'(q_rdata[CLS_BITS-1:0]);

	// digit generation and character streaming
	i2ra_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_mag    (b_mag),
		.q_cls    (b_cls),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last),
		.error    (error)
	);

	// an error result is a lone zero character
	`I2RA_ASSERT_IMP(a_err_lone, out_valid && error, character == i2ra_pkg::ERROR_CHAR && last)
	// a minus sign is always followed by digits
	`I2RA_ASSERT_IMP(a_minus_leads, out_valid && !error && character == i2ra_pkg::MINUS_CHAR, !last)
	// queue flags never contradict
	`I2RA_ASSERT_IMP(a_queue_flags, q_full, !q_empty)
	// a push into an empty queue is visible next cycle
	`I2RA_ASSERT_NXT(a_queue_push, q_push && q_empty, !q_empty)

endmodule

FILE: tb/i2ra_text_checker.sv
// scoreboard for the integer to radix ascii core: predicts the character stream
// of every accepted number and compares it with what leaves the output channel
// depends on i2ra_pkg for the radix limits and the special characters
module i2ra_text_checker #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [4:0]                   radix,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [6:0]                   character,
	input  logic                         last,
	input  logic                         error,
	output int                           pending,
	output int                           failures,
	output int                           chars_checked
);

	localparam string DIGIT_GLYPHS = "0123456789ABCDEF";

	typedef struct packed {
		logic [6:0] character;
		logic       last;
		logic       error;
	} text_char_t;

	text_char_t expected_text[$];

	function automatic void queue_char(input logic [6:0] c, input logic l, input logic e);
		text_char_t t;
		t.character = c;
		t.last = l;
		t.error = e;
		expected_text.push_back(t);
	endfunction

	// digits of the magnitude, most significant first; minus only in base ten
	function automatic void predict_text(input logic [VALUE_BITS-1:0] v, input logic [4:0] r);
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]            digits[VALUE_BITS];
		int                    n;
		byte                   glyph;
		if (r < i2ra_pkg::RADIX_MIN || r > i2ra_pkg::RADIX_MAX) begin
			queue_char(i2ra_pkg::ERROR_CHAR, 1'b1, 1'b1);
			return;
		end
		mag = v[VALUE_BITS-1] ? (0 - v) : v;
		n = 0;
		do begin
			digits[n] = 4'(mag % r);
			n++;
			mag = mag / r;
		end while (mag != 0 && n < VALUE_BITS);
		if (v[VALUE_BITS-1] && r == i2ra_pkg::RADIX_TEN)
			queue_char(i2ra_pkg::MINUS_CHAR, 1'b0, 1'b0);
		for (int i = n - 1; i >= 0; i--) begin
			glyph = DIGIT_GLYPHS[digits[i]];
			queue_char(glyph[6:0], i == 0, 1'b0);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			expected_text.delete();
			pending = 0;
			failures = 0;
			chars_checked = 0;
		end else begin
			// prediction first: the queue keeps older characters in front anyway
			if (in_valid && !in_stall)
				predict_text(value, radix);
			if (out_valid && !out_stall) begin
				chars_checked++;
				if (expected_text.size() == 0) begin
					failures++;
					$display("%0t: unexpected character %h last %b error %b, nothing pending",
						$time, character, last, error);
				end else begin
					want = expected_text.pop_front();
					if (want.character !== character || want.last !== last ||
							want.error !== error) begin
						failures++;
						$display({"%0t: text mismatch, expected char %h last %b error %b,",
							" got char %h last %b error %b"},
							$time, want.character, want.last, want.error,
							character, last, error);
					end
				end
			end
			pending = expected_text.size();
		end
	end

endmodule

FILE: tb/integer_to_radix_ascii_core_test.sv
// top of the integer to radix ascii regression: clock, reset, number stimulus,
// idle and stall phases and the verdict; checking lives in i2ra_text_checker
// depends on i2ra_pkg, integer_to_radix_ascii_core and i2ra_text_checker
module integer_to_radix_ascii_core_test;

	localparam int VALUE_BITS    = 32;
	localparam int PHASE_ITEMS   = 90;
	// the limit is far beyond the length of any good run
	localparam int CYCLE_LIMIT   = 1000000;
	// a short tail after the last predicted character is enough to catch stray characters
	localparam int DRAIN_CYCLES  = 200;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic [4:0]                   radix = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [6:0]                   character;
	logic                         last;
	logic                         error;

	int pending_chars;
	int mismatch_count;
	int chars_checked;
	int numbers_sent = 0;
	int bad_radix_sent = 0;
	int cycle_count = 0;

	// idle odds in percent for each side
	int send_idle_pct = 0;
	int stall_pct = 0;

	always #4 clk = ~clk;

	integer_to_radix_ascii_core #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.radix    (radix),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last),
		.error    (error)
	);

	i2ra_text_checker #(
		.VALUE_BITS(VALUE_BITS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.radix        (radix),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.character    (character),
		.last         (last),
		.error        (error),
		.pending      (pending_chars),
		.failures     (mismatch_count),
		.chars_checked(chars_checked)
	);

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// watchdog: a hung handshake or a lost character ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit of %0d reached with %0d characters pending",
			CYCLE_LIMIT, pending_chars);
		$display("Regression FAIL");
		$finish;
	end

	// one input transaction: optional idle gaps, then hold until accepted
	task automatic push_number(input logic [VALUE_BITS-1:0] v, input logic [4:0] r);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			// payload is don't-care while valid is low, so scramble it
			in_valid = 1'b0;
			value = $urandom;
			radix = 5'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		value = v;
		radix = r;
		do @(posedge clk); while (in_stall);
		numbers_sent++;
		if (r < i2ra_pkg::RADIX_MIN || r > i2ra_pkg::RADIX_MAX)
			bad_radix_sent++;
	endtask

	// mix of small, near-extreme and wide magnitudes of both signs
	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] v;
		case ($urandom_range(4))
			0: v = $urandom_range(0, 40);
			1: v = -$urandom_range(1, 40);
			2: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(1))
					v = -v;
			end
			3: v = $urandom_range(1) ? (32'h8000_0000 + $urandom_range(0, 3))
				: (32'h7FFF_FFFF - $urandom_range(0, 3));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// mostly legal bases with extra weight on ten, about one in ten out of range
	function automatic logic [4:0] pick_radix();
		int r;
		if ($urandom_range(9) == 0) begin
			r = $urandom_range(0, 16);
			return (r < 2) ? 5'(r) : 5'(r + 15);
		end
		if ($urandom_range(3) == 0)
			return i2ra_pkg::RADIX_TEN;
		return 5'($urandom_range(2, 16));
	endfunction

	initial begin
		// reset held low at the start, then released on a falling edge
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero, extremes, letters, sign handling and bad bases
		push_number(32'd0, 5'd10);
		push_number(32'd0, 5'd2);
		push_number(32'h7FFF_FFFF, 5'd10);
		push_number(32'h8000_0000, 5'd10);
		push_number(32'h8000_0000, 5'd16);
		push_number(32'h8000_0000, 5'd2);
		push_number(32'hFFFF_FFFF, 5'd2);
		push_number(32'hFFFF_FFFF, 5'd10);
		push_number(32'hFFFF_FFFF, 5'd16);
		push_number(32'h7FED_CBA9, 5'd16);
		push_number(32'hFEDC_BA98, 5'd16);
		push_number(32'd255, 5'd16);
		push_number(32'd15, 5'd16);
		push_number(32'd10, 5'd11);
		push_number(32'h7FFF_FFFF, 5'd3);
		push_number(-32'sd12345, 5'd7);
		push_number(-32'sd12345, 5'd10);
		push_number(32'd1, 5'd9);
		push_number(32'd1234, 5'd0);
		push_number(-32'sd1, 5'd1);
		push_number(32'd99, 5'd17);
		push_number(32'h8000_0000, 5'd31);

		// random phases: steady, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			repeat (PHASE_ITEMS)
				push_number(pick_value(), pick_radix());
		end

		@(negedge clk);
		in_valid = 1'b0;

		// let every predicted character arrive, then watch for strays
		while (pending_chars != 0)
			@(negedge clk);
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("converted %0d numbers (%0d with a bad radix) across four idle and stall mixes",
			numbers_sent, bad_radix_sent);
		$display("compared %0d output characters, %0d mismatches", chars_checked, mismatch_count);
		if (mismatch_count == 0 && pending_chars == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
